>>> rtl/spq_pkg.sv
`default_nettype none
package spq_pkg;

    localparam int unsigned CAPACITY_DEF = 16;
    localparam int unsigned WORD_W       = 32;
    localparam int unsigned OCC_W        = 5;

    localparam logic [1:0] CMD_ENQUEUE = 2'd0;
    localparam logic [1:0] CMD_DEQUEUE = 2'd1;
    localparam logic [1:0] CMD_CLEAR   = 2'd2;

    localparam logic [2:0] ST_ENQUEUED = 3'd0;
    localparam logic [2:0] ST_DEQUEUED = 3'd1;
    localparam logic [2:0] ST_EMPTY    = 3'd2;
    localparam logic [2:0] ST_FULL     = 3'd3;
    localparam logic [2:0] ST_CLEARED  = 3'd4;

    typedef struct packed {
        logic [1:0]               command;
        logic signed [WORD_W-1:0] data_value;
        logic signed [WORD_W-1:0] priority_req;
    } t_req;

    typedef struct packed {
        logic [2:0]               status;
        logic signed [WORD_W-1:0] data_out;
        logic signed [WORD_W-1:0] priority_out;
        logic [OCC_W-1:0]         occupancy;
    } t_res;

    // broadcast to every cell
    typedef struct packed {
        logic                     ins;
        logic                     del;
        logic signed [WORD_W-1:0] key;
        logic signed [WORD_W-1:0] data;
    } t_cell_ctl;

endpackage
`default_nettype wire

>>> rtl/spq_cell.sv
`default_nettype none
module spq_cell #(
    parameter int unsigned INDEX = 0,
    parameter int unsigned CNT_W = 5
) (
    input  wire                                  i_clk,
    input  wire spq_pkg::t_cell_ctl              i_ctl,
    input  wire [CNT_W-1:0]                      i_count,
    input  wire                                  i_left_ge,
    input  wire logic signed [spq_pkg::WORD_W-1:0] i_left_data,
    input  wire logic signed [spq_pkg::WORD_W-1:0] i_left_prio,
    input  wire logic signed [spq_pkg::WORD_W-1:0] i_right_data,
    input  wire logic signed [spq_pkg::WORD_W-1:0] i_right_prio,
    output logic                                 o_ge,
    output logic signed [spq_pkg::WORD_W-1:0]    o_data,
    output logic signed [spq_pkg::WORD_W-1:0]    o_prio
);

    logic signed [spq_pkg::WORD_W-1:0] r_data, n_data;
    logic signed [spq_pkg::WORD_W-1:0] r_prio, n_prio;
    logic                              occupied;

    assign occupied = (i_count > CNT_W'(INDEX));
    // held entry stays ahead of the new one
    assign o_ge     = occupied && (r_prio <= i_ctl.key);
    assign o_data   = r_data;
    assign o_prio   = r_prio;

    always_comb begin
        n_data = r_data;
        n_prio = r_prio;
        if (i_ctl.ins && !o_ge) begin
            if (i_left_ge) begin
                n_data = i_ctl.data;
                n_prio = i_ctl.key;
            end else begin
                n_data = i_left_data;
                n_prio = i_left_prio;
            end
        end else if (i_ctl.del) begin
            n_data = i_right_data;
            n_prio = i_right_prio;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
        r_prio <= n_prio;
    end

endmodule
`default_nettype wire

>>> rtl/sorted_priority_queue.sv
`default_nettype none
// Sorted min-priority queue of CAPACITY entries held in a row of cells,
// front entry in cell 0. Every cell compares its priority with the request
// key at once, so an enqueue opens a slot behind all entries of equal or
// smaller priority and the tail shifts one cell back; a dequeue shifts the
// row one cell forward. Each request yields one result in the output
// register; a new request is taken while the previous result is taken,
// so the rate is one request per cycle unless the output stalls. An
// enqueue into a full queue and a dequeue from an empty one leave the
// entries unchanged and report it in status.
module sorted_priority_queue #(
    parameter int unsigned CAPACITY = spq_pkg::CAPACITY_DEF
) (
    input  wire           i_clk,
    input  wire           i_rst_n,
    input  wire           i_in_valid,
    output logic          o_in_stall,
    input  wire spq_pkg::t_req i_in_req,
    output logic          o_out_valid,
    input  wire           i_out_stall,
    output spq_pkg::t_res o_out_res
);

    localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
    localparam int unsigned W     = spq_pkg::WORD_W;

    logic [CNT_W-1:0]     r_count, n_count;
    logic                 r_out_valid;
    spq_pkg::t_res        r_res, n_res;
    spq_pkg::t_cell_ctl   ctl;
    logic                 accept, is_clear, is_enq, full, empty;

    logic                 ge   [CAPACITY];
    logic signed [W-1:0]  data [CAPACITY];
    logic signed [W-1:0]  prio [CAPACITY];

    assign o_in_stall = r_out_valid && i_out_stall;
    assign accept     = i_in_valid && !o_in_stall;
    assign is_clear   = i_in_req.command[1];
    assign is_enq     = (i_in_req.command == spq_pkg::CMD_ENQUEUE);
    assign full       = (r_count == CNT_W'(CAPACITY));
    assign empty      = (r_count == '0);

    assign ctl.ins  = accept && is_enq && !full;
    assign ctl.del  = accept && !is_clear && !is_enq && !empty;
    assign ctl.key  = i_in_req.priority_req;
    assign ctl.data = i_in_req.data_value;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        spq_cell #(
            .INDEX(g),
            .CNT_W(CNT_W)
        ) u_cell (
            .i_clk       (i_clk),
            .i_ctl       (ctl),
            .i_count     (r_count),
            .i_left_ge   ((g == 0) ? 1'b1 : ge[(g == 0) ? 0 : g - 1]),
            .i_left_data (data[(g == 0) ? 0 : g - 1]),
            .i_left_prio (prio[(g == 0) ? 0 : g - 1]),
            .i_right_data(data[(g == CAPACITY - 1) ? g : g + 1]),
            .i_right_prio(prio[(g == CAPACITY - 1) ? g : g + 1]),
            .o_ge        (ge[g]),
            .o_data      (data[g]),
            .o_prio      (prio[g])
        );
    end

    always_comb begin
        n_count          = r_count;
        n_res.status     = spq_pkg::ST_CLEARED;
        n_res.data_out   = '0;
        n_res.priority_out = '0;
        if (is_clear) begin
            n_count = '0;
        end else if (is_enq) begin
            if (full) begin
                n_res.status = spq_pkg::ST_FULL;
            end else begin
                n_res.status = spq_pkg::ST_ENQUEUED;
                n_count      = r_count + 1'b1;
            end
        end else begin
            if (empty) begin
                n_res.status = spq_pkg::ST_EMPTY;
            end else begin
                n_res.status       = spq_pkg::ST_DEQUEUED;
                n_res.data_out     = data[0];
                n_res.priority_out = prio[0];
                n_count            = r_count - 1'b1;
            end
        end
        n_res.occupancy = spq_pkg::OCC_W'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_res <= n_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_res   = r_res;

endmodule
`default_nettype wire

>>> verif/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import spq_pkg::*;

    localparam int CAP       = CAPACITY_DEF;
    localparam int RUN_LIMIT = 500000;
    localparam int N_ITEMS   = 1724;
    localparam int HOLD_LEN  = 300;
    // the upper command code also clears
    localparam logic [1:0] CMD_CLEAR_ALT = 2'd3;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic in_valid  = 1'b0;
    logic in_stall;
    t_req in_req    = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    t_res out_res;

    sorted_priority_queue #(.CAPACITY(CAP)) dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_req   (in_req),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_res  (out_res)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    t_req pending_reqs[$];
    t_res expected_results[$];

    logic signed [WORD_W-1:0] held_data [CAP];
    logic signed [WORD_W-1:0] held_prio [CAP];
    int   held_count   = 0;

    int   cycle_cnt    = 0;
    int   accepted_cnt = 0;
    int   mismatch_cnt = 0;
    int   gap_left     = 0;
    int   stall_left   = 0;
    int   hold_left    = 0;
    int   holds_done   = 0;
    logic hold_on      = 1'b0;
    logic in_taken     = 1'b0;

    // sorted insert behind equal priorities, pop from the front
    function automatic t_res queue_step(t_req r);
        t_res res;
        int   pos;
        res = '0;
        if (r.command[1]) begin
            held_count = 0;
            res.status = ST_CLEARED;
        end else if (r.command == CMD_ENQUEUE) begin
            if (held_count >= CAP) begin
                res.status = ST_FULL;
            end else begin
                pos = 0;
                while (pos < held_count && $signed(held_prio[pos]) <= $signed(r.priority_req))
                    pos++;
                for (int i = held_count; i > pos; i--) begin
                    held_data[i] = held_data[i-1];
                    held_prio[i] = held_prio[i-1];
                end
                held_data[pos] = r.data_value;
                held_prio[pos] = r.priority_req;
                held_count++;
                res.status = ST_ENQUEUED;
            end
        end else begin
            if (held_count == 0) begin
                res.status = ST_EMPTY;
            end else begin
                res.data_out     = held_data[0];
                res.priority_out = held_prio[0];
                for (int i = 1; i < held_count; i++) begin
                    held_data[i-1] = held_data[i];
                    held_prio[i-1] = held_prio[i];
                end
                held_count--;
                res.status = ST_DEQUEUED;
            end
        end
        res.occupancy = OCC_W'(held_count);
        return res;
    endfunction

    function automatic t_req make_req(logic [1:0] cmd, logic [WORD_W-1:0] d,
                                      logic [WORD_W-1:0] p);
        t_req r;
        r.command      = cmd;
        r.data_value   = d;
        r.priority_req = p;
        return r;
    endfunction

    // spread 0 full range, 1 narrow band for ties, 2 extremes
    function automatic logic [WORD_W-1:0] rand_key(int spread);
        logic [WORD_W-1:0] k;
        if (spread == 0) begin
            k = $urandom;
        end else if (spread == 1) begin
            k = $urandom_range(0, 6) - 3;
        end else begin
            case ($urandom_range(0, 3))
                0: k = 32'h7fff_ffff;
                1: k = 32'h8000_0000;
                2: k = '0;
                default: k = '1;
            endcase
        end
        return k;
    endfunction

    function automatic logic [WORD_W-1:0] rand_word();
        logic [WORD_W-1:0] w;
        w = ($urandom_range(0, 7) == 0) ? rand_key(2) : $urandom;
        return w;
    endfunction

    function automatic logic [WORD_W-1:0] junk_word();
        logic [WORD_W-1:0] w;
        w = ($urandom_range(0, 2) == 0) ? $urandom : '0;
        return w;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if ((cycle_cnt / 500) % 4 == 0) return 0;
        if (r < 70) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // request driver
    always @(negedge clk) begin : drive_req
        logic nxt_valid;
        t_req nxt_req;
        nxt_valid = in_valid;
        nxt_req   = in_req;
        if (rst_n) begin
            if (in_valid && in_taken)
                nxt_valid = 1'b0;
            if (!nxt_valid) begin
                if (gap_left != 0) begin
                    gap_left--;
                end else if (pending_reqs.size() != 0) begin
                    nxt_req   = pending_reqs.pop_front();
                    nxt_valid = 1'b1;
                    gap_left  = pick_gap();
                end
            end
        end
        in_valid <= nxt_valid;
        in_req   <= nxt_req;
    end

    // long receiver hold-off so the queue backs up into the input
    always @(negedge clk) begin : long_hold
        if (hold_left != 0) begin
            hold_left--;
        end else if (holds_done < 2 && accepted_cnt >= (holds_done == 0 ? 40 : 900)) begin
            hold_left = HOLD_LEN;
            holds_done++;
        end
        hold_on <= (hold_left != 0);
    end

    always @(negedge clk) begin : drive_stall
        logic stall_now;
        stall_now = 1'b0;
        if (stall_left != 0) begin
            stall_now = 1'b1;
            stall_left--;
        end else if ((cycle_cnt / 700) % 4 != 1 && $urandom_range(0, 99) < 20) begin
            stall_now  = 1'b1;
            stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30)
                                                      : $urandom_range(0, 2);
        end
        out_stall <= rst_n && (stall_now || hold_on);
    end

    task automatic check_field(input string name, input logic [WORD_W-1:0] want,
                               input logic [WORD_W-1:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
            mismatch_cnt++;
        end
    endtask

    always @(posedge clk) begin : watch
        t_res want;
        in_taken <= rst_n && in_valid && !in_stall;
        if (rst_n) begin
            if (out_valid && !out_stall) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result, expected none actual %0h",
                             $time, out_res);
                    mismatch_cnt++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("status", want.status, out_res.status);
                    check_field("data_out", want.data_out, out_res.data_out);
                    check_field("priority_out", want.priority_out, out_res.priority_out);
                    check_field("occupancy", want.occupancy, out_res.occupancy);
                end
            end
            if (in_valid && !in_stall) begin
                expected_results.push_back(queue_step(in_req));
                accepted_cnt++;
            end
        end
    end

    always @(posedge clk) begin : watchdog
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= RUN_LIMIT) begin
            $display("sorted_priority_queue regression: fail");
            $finish;
        end
    end

    initial begin : stimulus
        int n;
        int m;
        int pick;
        int spread;
        int r;
        int total;

        // empty queue, then the upper clear code with junk fields
        pending_reqs.push_back(make_req(CMD_DEQUEUE, 32'hdead_beef, 32'h1234_5678));
        pending_reqs.push_back(make_req(CMD_CLEAR_ALT, 32'h7fff_ffff, 32'h8000_0000));
        // extremes and ties
        pending_reqs.push_back(make_req(CMD_ENQUEUE, 32'h7fff_ffff, 32'h7fff_ffff));
        pending_reqs.push_back(make_req(CMD_ENQUEUE, 32'h8000_0000, 32'h8000_0000));
        pending_reqs.push_back(make_req(CMD_ENQUEUE, 32'h0, 32'h0));
        pending_reqs.push_back(make_req(CMD_ENQUEUE, 32'hffff_ffff, 32'hffff_ffff));
        pending_reqs.push_back(make_req(CMD_ENQUEUE, 32'h1, 32'h0));
        pending_reqs.push_back(make_req(CMD_ENQUEUE, 32'h2, 32'h0));
        pending_reqs.push_back(make_req(CMD_ENQUEUE, 32'h3, 32'h7fff_ffff));
        pending_reqs.push_back(make_req(CMD_ENQUEUE, 32'h4, 32'h8000_0000));
        for (int i = 1; i <= 8; i++)
            pending_reqs.push_back(make_req(CMD_ENQUEUE, 32'h100 + i,
                                            (i % 2) ? 100 * i : -100 * i));
        // full and dropped
        pending_reqs.push_back(make_req(CMD_ENQUEUE, 32'haaaa_5555, 32'h5555_aaaa));
        pending_reqs.push_back(make_req(CMD_DEQUEUE, 32'h0, 32'h0));
        pending_reqs.push_back(make_req(CMD_DEQUEUE, 32'h0, 32'h0));
        pending_reqs.push_back(make_req(CMD_DEQUEUE, 32'hffff_ffff, 32'hffff_ffff));
        pending_reqs.push_back(make_req(CMD_CLEAR, 32'h5a5a_5a5a, 32'ha5a5_a5a5));
        pending_reqs.push_back(make_req(CMD_DEQUEUE, 32'h0, 32'h0));

        while (pending_reqs.size() < N_ITEMS) begin
            pick   = $urandom_range(0, 99);
            spread = $urandom_range(0, 2);
            if (pick < 30) begin
                // fill then drain, often running into full or empty
                n = $urandom_range(3, 20);
                repeat (n)
                    pending_reqs.push_back(make_req(CMD_ENQUEUE, rand_word(), rand_key(spread)));
                m = $urandom_range(n / 2, n + 3);
                repeat (m)
                    pending_reqs.push_back(make_req(CMD_DEQUEUE, junk_word(), junk_word()));
            end else if (pick < 80) begin
                repeat (20) begin
                    r = $urandom_range(0, 99);
                    if (r < 50)
                        pending_reqs.push_back(make_req(CMD_ENQUEUE, rand_word(),
                                                        rand_key(spread)));
                    else if (r < 95)
                        pending_reqs.push_back(make_req(CMD_DEQUEUE, junk_word(), junk_word()));
                    else if (r < 98)
                        pending_reqs.push_back(make_req(CMD_CLEAR, junk_word(), junk_word()));
                    else
                        pending_reqs.push_back(make_req(CMD_CLEAR_ALT, junk_word(), junk_word()));
                end
            end else if (pick < 90) begin
                // push past full, then wipe
                repeat ($urandom_range(17, 22))
                    pending_reqs.push_back(make_req(CMD_ENQUEUE, rand_word(), rand_key(spread)));
                pending_reqs.push_back(make_req($urandom_range(0, 1) ? CMD_CLEAR : CMD_CLEAR_ALT,
                                                junk_word(), junk_word()));
            end else begin
                repeat (10)
                    pending_reqs.push_back(make_req(2'($urandom_range(0, 3)), $urandom,
                                                    $urandom));
            end
        end
        total = pending_reqs.size();

        repeat (12) @(negedge clk);
        rst_n <= 1'b1;

        while (accepted_cnt < total)
            @(negedge clk);
        while (expected_results.size() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);

        if (mismatch_cnt == 0)
            $display("sorted_priority_queue regression: pass");
        else
            $display("sorted_priority_queue regression: fail");
        $finish;
    end

endmodule
